@@ hdl/fwc_pkg.sv @@
// ----------------------------------------------------------------------------
// fwc_pkg: shared types and constants of the flash write combiner
// Field widths, operation and result codes, register indexes and the
// structures passed between the input stage, merge stage and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package fwc_pkg;

    // default word size in bytes
    localparam int WORD_BYTES_DEF = 4;

    localparam int OFFSET_W = 24;
    localparam int END_W    = 25;
    localparam int ADDR_W   = 32;
    localparam int LEN_W    = 25;
    localparam int DATA_W   = 32;
    localparam int BYTE_W   = 8;

    // apb register map
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam logic REG_REGION_BASE   = 1'b0;
    localparam logic REG_REGION_LENGTH = 1'b1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result kinds
    localparam logic KIND_PROGRAM     = 1'b0;
    localparam logic KIND_RANGE_ERROR = 1'b1;

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

    // registered input word with the precomputed word index
    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   byte_value;
        logic [END_W-1:0]    call_end;
        logic                last_of_call;
        logic [OFFSET_W-1:0] quot;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] word_address;
        logic [DATA_W-1:0] word_data;
        logic              final_res;
    } result_t;

    // up to two results produced by one item, oldest in first
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } results_t;

endpackage

`default_nettype wire

@@ hdl/fwc_in_stage.sv @@
// ----------------------------------------------------------------------------
// fwc_in_stage: input register of the flash write combiner
// Registers the accepted byte word together with offset / WORD_BYTES, formed
// by a reciprocal multiplication, so the merge stage only scales it back.
// ----------------------------------------------------------------------------
`default_nettype none

module fwc_in_stage #(
    parameter int WORD_BYTES = 4
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [fwc_pkg::OFFSET_W-1:0]    s_offset,
    input  wire logic [fwc_pkg::BYTE_W-1:0]      s_byte_value,
    input  wire logic [fwc_pkg::END_W-1:0]       s_call_end,
    input  wire logic                            s_last_of_call,
    input  wire logic                            take,
    output logic                                 item_valid,
    output fwc_pkg::item_t                       item
);
    import fwc_pkg::*;

    // exact for every 24 bit offset: RECIP*W - 2**SHIFT < 2**(SHIFT-OFFSET_W)
    localparam int SHIFT   = OFFSET_W + 3;
    localparam int RECIP_W = SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WORD_BYTES) - 64'd1) / 64'(WORD_BYTES));
    localparam int PROD_W  = OFFSET_W + RECIP_W;

    logic                valid_reg;
    logic                valid_next;
    item_t               item_reg;
    logic [PROD_W-1:0]   prod;
    logic                accept;

    assign s_ready    = !valid_reg || take;
    assign accept     = s_valid && s_ready;
    assign prod       = PROD_W'(s_offset) * PROD_W'(RECIP);
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op           <= s_op;
            item_reg.offset       <= s_offset;
            item_reg.byte_value   <= s_byte_value;
            item_reg.call_end     <= s_call_end;
            item_reg.last_of_call <= s_last_of_call;
            item_reg.quot         <= prod[PROD_W-1:SHIFT];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hdl/fwc_merge.sv @@
// ----------------------------------------------------------------------------
// fwc_merge: held word state and merge logic
// Merges one byte into the held word, decides which words leave and updates
// the held word, its base and the aligned-start flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fwc_merge #(
    parameter int WORD_BYTES = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          fire,
    input  wire fwc_pkg::item_t                item,
    input  wire logic [fwc_pkg::ADDR_W-1:0]    region_base,
    input  wire logic [fwc_pkg::LEN_W-1:0]     region_length,
    output fwc_pkg::results_t                  results
);
    import fwc_pkg::*;

    localparam int WORD_W = BYTE_W * WORD_BYTES;
    localparam int LANE_W = $clog2(WORD_BYTES);
    localparam logic [WORD_W-1:0] ERASED_WORD = {WORD_BYTES{ERASED_BYTE}};

    logic [WORD_W-1:0]   held_word_reg,  held_word_next;
    logic [OFFSET_W-1:0] held_base_reg,  held_base_next;
    logic                held_valid_reg, held_valid_next;
    logic                aligned_reg,    aligned_next;

    logic [OFFSET_W-1:0] diff;
    logic [OFFSET_W-1:0] base_new;
    logic [OFFSET_W-1:0] rem;
    logic                in_win;
    logic [OFFSET_W-1:0] cur_base;
    logic [LANE_W-1:0]   cur_lane;
    logic                cur_aligned;
    logic [WORD_W-1:0]   cur_word;
    logic [WORD_W-1:0]   merged;
    logic                emit_new;
    result_t             old_res;
    result_t             new_res;
    result_t             err_res;

    always_comb begin
        diff     = item.offset - held_base_reg;
        in_win   = held_valid_reg && (item.offset >= held_base_reg)
                   && (diff < OFFSET_W'(WORD_BYTES));
        base_new = OFFSET_W'(item.quot * OFFSET_W'(WORD_BYTES));
        rem      = item.offset - base_new;

        if (in_win) begin
            cur_base    = held_base_reg;
            cur_lane    = diff[LANE_W-1:0];
            cur_aligned = aligned_reg;
            cur_word    = held_word_reg;
        end else begin
            cur_base    = base_new;
            cur_lane    = rem[LANE_W-1:0];
            cur_aligned = (rem == '0);
            cur_word    = ERASED_WORD;
        end

        merged = cur_word;
        for (int i = 0; i < WORD_BYTES; i++) begin
            if (cur_lane == LANE_W'(i)) begin
                merged[i*BYTE_W +: BYTE_W] = item.byte_value;
            end
        end

        emit_new = (cur_lane == LANE_W'(WORD_BYTES - 1))
                   && (!item.last_of_call || cur_aligned);

        old_res.kind         = KIND_PROGRAM;
        old_res.word_address = region_base + ADDR_W'(held_base_reg);
        old_res.word_data    = DATA_W'(held_word_reg);
        old_res.final_res    = 1'b1;

        new_res.kind         = KIND_PROGRAM;
        new_res.word_address = region_base + ADDR_W'(cur_base);
        new_res.word_data    = DATA_W'(merged);
        new_res.final_res    = 1'b1;

        err_res.kind         = KIND_RANGE_ERROR;
        err_res.word_address = '0;
        err_res.word_data    = '0;
        err_res.final_res    = 1'b1;

        held_word_next  = held_word_reg;
        held_base_next  = held_base_reg;
        held_valid_next = held_valid_reg;
        aligned_next    = aligned_reg;
        results.count   = 2'd0;
        results.first   = old_res;
        results.second  = new_res;

        if (item.op == OP_FLUSH) begin
            if (held_valid_reg) begin
                results.count   = 2'd1;
                held_word_next  = ERASED_WORD;
                held_base_next  = '0;
                held_valid_next = 1'b0;
            end
            aligned_next = 1'b0;
        end else if (item.call_end > region_length) begin
            // rejected call, only its last byte reports
            if (item.last_of_call) begin
                results.count = 2'd1;
                results.first = err_res;
                aligned_next  = 1'b0;
            end
        end else begin
            if (emit_new) begin
                held_word_next  = ERASED_WORD;
                held_base_next  = '0;
                held_valid_next = 1'b0;
                aligned_next    = 1'b0;
            end else begin
                held_word_next  = merged;
                held_base_next  = cur_base;
                held_valid_next = 1'b1;
                aligned_next    = cur_aligned && !item.last_of_call;
            end

            if (held_valid_reg && !in_win) begin
                // byte outside the window pushes the held word out first
                if (emit_new) begin
                    results.count           = 2'd2;
                    results.first.final_res = 1'b0;
                end else begin
                    results.count = 2'd1;
                end
            end else if (emit_new) begin
                results.count = 2'd1;
                results.first = new_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_word_reg  <= ERASED_WORD;
            held_base_reg  <= '0;
            held_valid_reg <= 1'b0;
            aligned_reg    <= 1'b0;
        end else if (fire) begin
            held_word_reg  <= held_word_next;
            held_base_reg  <= held_base_next;
            held_valid_reg <= held_valid_next;
            aligned_reg    <= aligned_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/fwc_result_fifo.sv @@
// ----------------------------------------------------------------------------
// fwc_result_fifo: result queue of the flash write combiner
// Four entry queue taking up to two results a cycle and giving one word a
// cycle while m_ready is high; room flags space for a full item.
// ----------------------------------------------------------------------------
`default_nettype none

module fwc_result_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire fwc_pkg::results_t             results,
    output logic                               room,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output fwc_pkg::result_t                   head
);
    import fwc_pkg::*;

    localparam int DEPTH   = 4;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = PTR_W + 1;

    result_t             mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]  count_reg,  count_next;
    logic [COUNT_W-1:0]  n_push;
    logic                pop;

    assign n_push  = push ? COUNT_W'(results.count) : '0;
    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign room    = (count_reg <= COUNT_W'(DEPTH - 2));
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + n_push[PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + n_push - COUNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != '0) begin
            mem[wr_ptr_reg] <= results.first;
        end
        if (n_push == COUNT_W'(2)) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= results.second;
        end
    end

    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(DEPTH))
        else $error("result queue overflow");

    // a pop with nothing pushed drops the fill by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && n_push == '0) |=> (count_reg == $past(count_reg) - COUNT_W'(1)))
        else $error("result queue fill miscounted on pop");

    // only the second of a pair of results closes the item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && results.count == 2'd2)
            |-> (!results.first.final_res && results.second.final_res))
        else $error("final flag misplaced in result pair");

endmodule

`default_nettype wire

@@ hdl/flash_write_combiner.sv @@
// ----------------------------------------------------------------------------
// flash_write_combiner: gathers byte writes into aligned flash words
// Path: a byte word is registered, merged and queued before the result port.
// Throughput: one byte word a cycle while the queue has room; the merge stage
// runs at most once per cycle and the result port gives one word a cycle
// while m_ready is high. The four entry result queue decouples the two sides.
// Reset: aresetn is synchronous, active low; it empties both stages and the
// queue, clears the config registers and sets the held word to erased 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_write_combiner #(
    parameter int WORD_BYTES = fwc_pkg::WORD_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // apb config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [fwc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [fwc_pkg::PDATA_W-1:0]   pwdata,
    output logic [fwc_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // byte write channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_op,
    input  wire logic [fwc_pkg::OFFSET_W-1:0]  s_offset,
    input  wire logic [fwc_pkg::BYTE_W-1:0]    s_byte_value,
    input  wire logic [fwc_pkg::END_W-1:0]     s_call_end,
    input  wire logic                          s_last_of_call,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_kind,
    output logic [fwc_pkg::ADDR_W-1:0]         m_word_address,
    output logic [fwc_pkg::DATA_W-1:0]         m_word_data,
    output logic                               m_final_res
);
    import fwc_pkg::*;

    // config registers
    logic [ADDR_W-1:0] region_base_reg;
    logic [LEN_W-1:0]  region_length_reg;
    logic              cfg_write;
    logic              cfg_index;

    // pipeline control
    logic              item_valid;
    item_t             item;
    logic              room;
    logic              fire;
    results_t          results;
    result_t           head;

    // apb: no wait states, register picked by the word address bit
    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_base_reg   <= '0;
            region_length_reg <= '0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_REGION_BASE:   region_base_reg   <= pwdata;
                REG_REGION_LENGTH: region_length_reg <= pwdata[LEN_W-1:0];
                default:           region_base_reg   <= region_base_reg;
            endcase
        end
    end

    // read back, zero for unaligned addresses
    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (cfg_index)
                REG_REGION_BASE:   prdata = region_base_reg;
                REG_REGION_LENGTH: prdata = PDATA_W'(region_length_reg);
                default:           prdata = '0;
            endcase
        end
    end

    // merge stage runs whenever a word waits and the queue can take two results
    assign fire = item_valid && room;

    fwc_in_stage #(
        .WORD_BYTES (WORD_BYTES)
    ) u_in_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_offset       (s_offset),
        .s_byte_value   (s_byte_value),
        .s_call_end     (s_call_end),
        .s_last_of_call (s_last_of_call),
        .take           (fire),
        .item_valid     (item_valid),
        .item           (item)
    );

    fwc_merge #(
        .WORD_BYTES (WORD_BYTES)
    ) u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (item),
        .region_base   (region_base_reg),
        .region_length (region_length_reg),
        .results       (results)
    );

    fwc_result_fifo u_result_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .results (results),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    // result channel straight from the queue head
    assign m_kind         = head.kind;
    assign m_word_address = head.word_address;
    assign m_word_data    = head.word_data;
    assign m_final_res    = head.final_res;

endmodule

`default_nettype wire
